/* hw/rtl/utf16d_pkg.sv */
// Package for the UTF-8 to UTF-16 code unit decoder.
// Holds the item, result and group types and the per-position judge function.
// No dependencies.
package utf16d_pkg;

  localparam int unsigned MaxResults = 3;
  localparam logic [15:0] SurrogateBase = 16'hD800;

  typedef enum logic [1:0] {
    JUDGE_NONE,
    JUDGE_UNIT,
    JUDGE_STOP
  } judge_e;

  typedef struct packed {
    judge_e      kind;
    logic [15:0] unit;
  } judge_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        buffer_done;
  } result_t;

  typedef struct packed {
    logic [1:0]                 cnt;
    result_t [MaxResults-1:0]   res;
  } group_t;

  // Judge byte b with 'ahead' bytes (0..2) following it in the buffer.
  function automatic judge_t judge(input logic [7:0] b, input logic [1:0] ahead,
                                   input logic [7:0] n1, input logic [7:0] n2);
    judge_t      j;
    logic [15:0] v3;
    logic [15:0] v2;
    v3 = {b[3:0], n1[5:0], n2[5:0]};
    v2 = {5'd0, b[4:0], n1[5:0]};
    j.kind = JUDGE_NONE;
    j.unit = '0;
    if (b[7] == 1'b0) begin
      j.kind = JUDGE_UNIT;
      j.unit = {8'd0, b};
    end else if (b[7:6] == 2'b10) begin
      j.kind = JUDGE_NONE;
    end else if (b[7:4] == 4'b1110) begin
      if (ahead < 2'd2) begin
        j.kind = JUDGE_STOP;
      end else if (v3 < SurrogateBase) begin
        j.kind = JUDGE_UNIT;
        j.unit = v3;
      end
    end else if (b[7:5] == 3'b110) begin
      if ((ahead != 2'd0) && (v2 < SurrogateBase)) begin
        j.kind = JUDGE_UNIT;
        j.unit = v2;
      end
    end
    return j;
  endfunction

endpackage

/* hw/rtl/utf16d_skid.sv */
// Input register with skid stage for the decoder.
// Depends on utf16d_pkg for the item type.
module utf16d_skid import utf16d_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_item_i,
  output logic     in_stall_o,
  input  logic     pop_i,
  output logic     main_valid_o,
  output in_item_t main_item_o
);

  logic     main_valid_q, main_valid_d;
  logic     skid_valid_q, skid_valid_d;
  in_item_t main_q, main_d;
  in_item_t skid_q, skid_d;
  logic     accept;

  assign in_stall_o   = skid_valid_q;
  assign accept       = in_valid_i && !skid_valid_q;
  assign main_valid_o = main_valid_q;
  assign main_item_o  = main_q;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (pop_i && main_valid_q) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else if (accept) begin
        main_d = in_item_i;
      end else begin
        main_valid_d = 1'b0;
      end
    end else if (accept) begin
      if (!main_valid_q) begin
        main_d       = in_item_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = in_item_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

/* hw/rtl/utf16d_window.sv */
// Look-ahead window and position judging for the decoder.
// Depends on utf16d_pkg for the judge function and group type.
module utf16d_window import utf16d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   item_i,
  input  logic       advance_i,
  output group_t     group_o,
  output logic [1:0] held_o
);

  logic [7:0] la0_q, la0_d;
  logic [7:0] la1_q, la1_d;
  logic [1:0] held_q, held_d;
  logic [7:0] win0, win1, win2;
  judge_t     j0, j1, j2;

  assign held_o = held_q;

  always_comb begin
    win0 = (held_q == 2'd0) ? item_i.data_byte : la0_q;
    win1 = (held_q == 2'd1) ? item_i.data_byte : la1_q;
    win2 = held_q[1] ? item_i.data_byte : 8'd0;
    j0   = judge(win0, held_q, win1, win2);
    j1   = judge(win1, held_q - 2'd1, win2, 8'd0);
    j2   = judge(win2, 2'd0, 8'd0, 8'd0);
  end

  always_comb begin
    logic [MaxResults-1:0] hit;
    logic [15:0]           units [MaxResults];
    logic                  s0, s1;
    logic [1:0]            cnt;
    group_t                g;
    s0       = j0.kind == JUDGE_STOP;
    s1       = (held_q != 2'd0) && !s0 && (j1.kind == JUDGE_STOP);
    units[0] = j0.unit;
    units[1] = j1.unit;
    units[2] = j2.unit;
    if (item_i.final_byte) begin
      hit[0] = j0.kind == JUDGE_UNIT;
      hit[1] = (held_q != 2'd0) && !s0 && (j1.kind == JUDGE_UNIT);
      hit[2] = held_q[1] && !s0 && !s1 && (j2.kind == JUDGE_UNIT);
    end else begin
      hit[0] = held_q[1] && (j0.kind == JUDGE_UNIT);
      hit[1] = 1'b0;
      hit[2] = 1'b0;
    end
    g   = '0;
    cnt = 2'd0;
    for (int i = 0; i < MaxResults; i++) begin
      if (hit[i]) begin
        g.res[cnt].code_unit  = units[i];
        g.res[cnt].unit_valid = 1'b1;
        cnt = cnt + 2'd1;
      end
    end
    if (item_i.final_byte) begin
      if (cnt == 2'd0) begin
        g.res[0].buffer_done = 1'b1;
        cnt = 2'd1;
      end else begin
        g.res[cnt - 2'd1].buffer_done = 1'b1;
      end
    end
    g.cnt   = cnt;
    group_o = g;
  end

  always_comb begin
    la0_d  = la0_q;
    la1_d  = la1_q;
    held_d = held_q;
    if (advance_i) begin
      if (item_i.final_byte) begin
        la0_d  = 8'd0;
        la1_d  = 8'd0;
        held_d = 2'd0;
      end else if (held_q[1]) begin
        la0_d = win1;
        la1_d = win2;
      end else begin
        la0_d  = win0;
        la1_d  = win1;
        held_d = held_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      la0_q  <= 8'd0;
      la1_q  <= 8'd0;
      held_q <= 2'd0;
    end else begin
      la0_q  <= la0_d;
      la1_q  <= la1_d;
      held_q <= held_d;
    end
  end

endmodule

/* hw/rtl/utf16d_resq.sv */
// Result register for the decoder: holds one group of up to three results
// and shifts them out one per cycle while out_stall_i is low. Depends on utf16d_pkg.
module utf16d_resq import utf16d_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    main_valid_i,
  input  group_t  group_i,
  output logic    advance_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t result_o
);

  logic [1:0]               cnt_q, cnt_d;
  result_t [MaxResults-1:0] res_q, res_d;
  logic                     take;

  assign out_valid_o = cnt_q != 2'd0;
  assign take        = out_valid_o && !out_stall_i;
  assign result_o    = res_q[0];
  assign advance_o   = main_valid_i &&
                       ((group_i.cnt == 2'd0) || (cnt_q == 2'd0) ||
                        (take && (cnt_q == 2'd1)));

  always_comb begin
    cnt_d = cnt_q;
    res_d = res_q;
    if (advance_o && (group_i.cnt != 2'd0)) begin
      cnt_d = group_i.cnt;
      res_d = group_i.res;
    end else if (take) begin
      cnt_d = cnt_q - 2'd1;
      for (int i = 0; i < MaxResults - 1; i++) begin
        res_d[i] = res_q[i + 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

/* hw/rtl/utf8_to_utf16_unit_decoder.sv */
// UTF-8 to 16-bit code unit decoder, top level.
// Depends on utf16d_pkg, utf16d_skid, utf16d_window and utf16d_resq.
//
// Takes one byte per cycle while in_stall_o is low and gives results in
// order, one per cycle while out_stall_i is low; a byte is held in the input
// register and its results in the result register. A non-final byte gives
// at most one result; the flagged final byte flushes the look-ahead window
// and gives one to three results (a bare end marker if none decode), which
// leave the result register one per cycle while input is held off. The
// input side is a register plus a skid stage, so in_stall_o is registered
// and does not follow out_stall_i in the same cycle.
module utf8_to_utf16_unit_decoder import utf16d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] code_unit_o,
  output logic        unit_valid_o,
  output logic        buffer_done_o
);

  in_item_t   in_item;
  in_item_t   main_item;
  logic       main_valid;
  logic       advance;
  group_t     group;
  result_t    result;
  logic [1:0] held;

  assign in_item.data_byte  = data_byte_i;
  assign in_item.final_byte = final_byte_i;

  utf16d_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item),
    .in_stall_o  (in_stall_o),
    .pop_i       (advance),
    .main_valid_o(main_valid),
    .main_item_o (main_item)
  );

  utf16d_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (main_item),
    .advance_i(advance),
    .group_o  (group),
    .held_o   (held)
  );

  utf16d_resq u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .main_valid_i(main_valid),
    .group_i     (group),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign code_unit_o   = result.code_unit;
  assign unit_valid_o  = result.unit_valid;
  assign buffer_done_o = result.buffer_done;

  a_marker_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !unit_valid_o |-> buffer_done_o && (code_unit_o == 16'd0))
    else $error("end marker result malformed");

  a_no_surrogate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unit_valid_o |-> code_unit_o < SurrogateBase)
    else $error("decoded unit at or above surrogate range");

  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && main_item.final_byte |=> held == 2'd0)
    else $error("window not empty after final item");

  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !main_item.final_byte && (held != 2'd0) |=> held == 2'd2 || held == 2'd3 ||
    held == $past(held) + 2'd1)
    else $error("window fill count skipped");

endmodule
